// ===== rtl/tmvg_pkg.sv =====
// ----------------------------------------------------------------------------
// tmvg_pkg
// Shared types, constants and helpers for the torus mesh vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmvg_pkg;

  localparam int MAX_SLICES      = 256;
  localparam int MAX_STACKS      = 256;
  localparam int SINE_TABLE_SIZE = 1024;

  localparam int CNT_W   = 9;
  localparam int FRAC_W  = 15;
  localparam int NUM_W   = CNT_W + FRAC_W;
  localparam int PHASE_W = $clog2(SINE_TABLE_SIZE);
  localparam int QTR_W   = PHASE_W - 2;
  localparam int QUARTER = SINE_TABLE_SIZE / 4;
  localparam int ONE14   = 16384;
  localparam int ONE15   = 32768;

  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = NUM_W / DIV_BITS;

  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_TUBE_RADIUS,
    REG_RING_RADIUS,
    REG_SLICE_COUNT,
    REG_STACK_COUNT
  } reg_idx_t;

  typedef logic [14:0] qw_tab_t [0:QUARTER];

  typedef struct packed {
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [17:0] vertex_number;
    logic        tri_valid;
    logic [17:0] tri_base;
    logic        last;
  } vtx_meta_t;

  function automatic qw_tab_t qw_build();
    qw_tab_t     tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] res;
    for (int t = 0; t <= QUARTER; t++) begin
      if (t >= QUARTER) begin
        tab[t] = 15'(ONE14);
      end else begin
        x   = (64'(t) << 30) / QUARTER;
        x2  = (x * x) >> 30;
        acc = 64'd172272;
        acc = 64'd5026993 - ((x2 * acc) >> 30);
        acc = 64'd85569306 - ((x2 * acc) >> 30);
        acc = 64'd693598668 - ((x2 * acc) >> 30);
        acc = 64'd1686629713 - ((x2 * acc) >> 30);
        res = (x * acc) >> 30;
        res = (res + 64'd32768) >> 16;
        if (res > 64'(ONE14)) res = 64'(ONE14);
        tab[t] = 15'(res);
      end
    end
    return tab;
  endfunction

  localparam qw_tab_t QW_TAB = qw_build();

  function automatic logic signed [15:0] sine_at(input logic [PHASE_W-1:0] p);
    logic [QTR_W-1:0] off;
    logic [QTR_W:0]   t;
    logic [15:0]      mag;
    off = p[QTR_W-1:0];
    if (p[QTR_W]) t = (QTR_W+1)'(QUARTER) - {1'b0, off};
    else t = {1'b0, off};
    mag = 16'(QW_TAB[t]);
    return p[PHASE_W-1] ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic logic signed [47:0] rnd14(input logic signed [47:0] v);
    logic signed [47:0] mag;
    mag = -v;
    if (v < 0) return -((mag + 48'sd8192) >>> 14);
    return (v + 48'sd8192) >>> 14;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] hi);
    if (v < CNT_W'(3)) return CNT_W'(3);
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tmvg_if.sv =====
// ----------------------------------------------------------------------------
// tmvg_if
// Valid/ready channels: grid points in, vertices out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmvg_grid_if;
  logic       valid;
  logic       ready;
  logic [7:0] slice_index;
  logic [8:0] stack_index;
  modport source(output valid, slice_index, stack_index, input ready);
  modport sink(input valid, slice_index, stack_index, output ready);
endinterface

interface tmvg_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [17:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic [17:0]        vertex_number;
  logic               tri_valid;
  logic [17:0]        tri_base;
  logic               last;
  modport source(output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                 vertex_number, tri_valid, tri_base, last, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
               vertex_number, tri_valid, tri_base, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/tmvg_div.sv =====
// ----------------------------------------------------------------------------
// tmvg_div
// Pipelined restoring divider, a few quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tmvg_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [tmvg_pkg::NUM_W-1:0]  num,
  input  wire logic [tmvg_pkg::CNT_W-1:0]  den,
  output logic      [tmvg_pkg::NUM_W-1:0]  quo
);

  localparam int NW = tmvg_pkg::NUM_W;
  localparam int DW = tmvg_pkg::CNT_W;
  localparam int NS = tmvg_pkg::DIV_STAGES;

  logic [DW-1:0] rem_d [0:NS];
  logic [NW-1:0] num_d [0:NS];
  logic [NW-1:0] quo_d [0:NS];

  assign rem_d[0] = '0;
  assign num_d[0] = num;
  assign quo_d[0] = '0;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] r;
    logic [NW-1:0] n;
    logic [NW-1:0] q;
    logic [DW:0]   t;
    logic [DW-1:0] rem_q;
    logic [NW-1:0] num_q;
    logic [NW-1:0] quo_q;

    always_comb begin
      r = rem_d[s];
      n = num_d[s];
      q = quo_d[s];
      t = '0;
      for (int b = 0; b < tmvg_pkg::DIV_BITS; b++) begin
        t = {r, n[NW-1]};
        n = {n[NW-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
          r = DW'(t - {1'b0, den});
          q = {q[NW-2:0], 1'b1};
        end else begin
          r = t[DW-1:0];
          q = {q[NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= r;
        num_q <= n;
        quo_q <= q;
      end
    end

    assign rem_d[s+1] = rem_q;
    assign num_d[s+1] = num_q;
    assign quo_d[s+1] = quo_q;
  end

  assign quo = quo_d[NS];

endmodule

`default_nettype wire

// ===== rtl/torus_mesh_vertex_generator_top.sv =====
// ----------------------------------------------------------------------------
// torus_mesh_vertex_generator_top
// Emits two torus vertices (slice i and i+1) for every grid point.
//
//   channel | dir | handshake   | payload
//   grid    | in  | valid/ready | slice_index, stack_index
//   vertex  | out | valid/ready | position, normal, texture, indices, last
//   apb     | in  | psel/penable| tube/ring radius, slice/stack count
//
// Each vertex of a grid point takes one slot of the pipeline.
// A grid point passes the holding register, six divider stages, lookup
// and four multiply/round stages on its way to the vertex channel.
// rst clears the valid bits and sets the config registers to defaults; no clearing pass.
// A stalled output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module torus_mesh_vertex_generator_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tmvg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  tmvg_grid_if.sink                          grid,
  tmvg_vertex_if.source                      vertex
);

  localparam int NS = tmvg_pkg::DIV_STAGES;
  localparam int CW = tmvg_pkg::CNT_W;
  localparam int FW = tmvg_pkg::FRAC_W;
  localparam int PW = tmvg_pkg::PHASE_W;

  logic [15:0]   tube_radius;
  logic [15:0]   ring_radius;
  logic [CW-1:0] slice_count;
  logic [CW-1:0] stack_count;
  logic [CW-1:0] ns;
  logic [CW-1:0] nt;
  tmvg_pkg::reg_idx_t widx;

  assign pready = 1'b1;
  assign widx   = tmvg_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tube_radius <= 16'd256;
      ring_radius <= 16'd512;
      slice_count <= CW'(16);
      stack_count <= CW'(16);
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        tmvg_pkg::REG_TUBE_RADIUS: tube_radius <= pwdata[15:0];
        tmvg_pkg::REG_RING_RADIUS: ring_radius <= pwdata[15:0];
        tmvg_pkg::REG_SLICE_COUNT: slice_count <= pwdata[CW-1:0];
        tmvg_pkg::REG_STACK_COUNT: stack_count <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      tmvg_pkg::REG_TUBE_RADIUS: prdata = {16'd0, tube_radius};
      tmvg_pkg::REG_RING_RADIUS: prdata = {16'd0, ring_radius};
      tmvg_pkg::REG_SLICE_COUNT: prdata = {{(32-CW){1'b0}}, slice_count};
      tmvg_pkg::REG_STACK_COUNT: prdata = {{(32-CW){1'b0}}, stack_count};
      default:                   prdata = '0;
    endcase
  end

  assign ns = tmvg_pkg::clamp_count(slice_count, CW'(tmvg_pkg::MAX_SLICES));
  assign nt = tmvg_pkg::clamp_count(stack_count, CW'(tmvg_pkg::MAX_STACKS));

  // holding register: split one grid point into two vertex slots
  logic          adv;
  logic          hold_valid;
  logic          hold_side;
  logic [7:0]    hold_slice;
  logic [8:0]    hold_stack;
  logic [CW-1:0] hold_k;

  assign grid.ready = !hold_valid || (hold_side && adv);
  assign hold_k     = CW'({1'b0, hold_slice}) + CW'(hold_side);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_side  <= 1'b0;
    end else if (grid.valid && grid.ready) begin
      hold_valid <= 1'b1;
      hold_side  <= 1'b0;
    end else if (adv && hold_valid) begin
      if (!hold_side) hold_side <= 1'b1;
      else hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (grid.valid && grid.ready) begin
      hold_slice <= grid.slice_index;
      hold_stack <= grid.stack_index;
    end
  end

  // dividers: j*2^15/nt and k*2^15/ns
  logic [tmvg_pkg::NUM_W-1:0] quo_j;
  logic [tmvg_pkg::NUM_W-1:0] quo_k;

  tmvg_div u_div_j (
    .clk (clk),
    .en  (adv),
    .num ({hold_stack, {FW{1'b0}}}),
    .den (nt),
    .quo (quo_j)
  );

  tmvg_div u_div_k (
    .clk (clk),
    .en  (adv),
    .num ({hold_k, {FW{1'b0}}}),
    .den (ns),
    .quo (quo_k)
  );

  logic       dv [0:NS-1];
  logic [7:0] di [0:NS-1];
  logic [8:0] dj [0:NS-1];
  logic       ds [0:NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) dv[s] <= 1'b0;
    end else if (adv) begin
      dv[0] <= hold_valid;
      for (int s = 1; s < NS; s++) dv[s] <= dv[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      di[0] <= hold_slice;
      dj[0] <= hold_stack;
      ds[0] <= hold_side;
      for (int s = 1; s < NS; s++) begin
        di[s] <= di[s-1];
        dj[s] <= dj[s-1];
        ds[s] <= ds[s-1];
      end
    end
  end

  // lookup stage
  logic [PW-1:0]      pb;
  logic [PW-1:0]      pa;
  logic [17:0]        base_sum;
  logic [17:0]        base;
  tmvg_pkg::vtx_meta_t meta_n;

  assign pb       = quo_j[FW-1 -: PW];
  assign pa       = quo_k[FW-1 -: PW];
  assign base_sum = 18'(di[NS-1]) * (18'(nt) + 18'd1) + 18'(dj[NS-1]);
  assign base     = {base_sum[16:0], 1'b0};

  always_comb begin
    meta_n.tex_u         = (quo_j > tmvg_pkg::NUM_W'(tmvg_pkg::ONE15)) ?
                           16'(tmvg_pkg::ONE15) : quo_j[15:0];
    meta_n.tex_v         = (quo_k > tmvg_pkg::NUM_W'(tmvg_pkg::ONE15)) ?
                           16'(tmvg_pkg::ONE15) : quo_k[15:0];
    meta_n.vertex_number = base | 18'(ds[NS-1]);
    meta_n.tri_valid     = dj[NS-1] < nt;
    meta_n.tri_base      = meta_n.tri_valid ? base : 18'd0;
    meta_n.last          = ds[NS-1];
  end

  logic                vp;
  logic signed [15:0]  p_sb, p_cb, p_sa, p_ca;
  tmvg_pkg::vtx_meta_t p_meta;

  // first products
  logic                vm1;
  logic signed [32:0]  m1_rcb, m1_rsb;
  logic signed [31:0]  m1_nx, m1_nz;
  logic signed [15:0]  m1_sb, m1_sa, m1_ca;
  tmvg_pkg::vtx_meta_t m1_meta;

  // rounding and ring radius
  logic                vm2;
  logic signed [18:0]  m2_rad;
  logic signed [16:0]  m2_py;
  logic signed [15:0]  m2_nx, m2_nz, m2_sb, m2_sa, m2_ca;
  tmvg_pkg::vtx_meta_t m2_meta;

  // position products
  logic                vm3;
  logic signed [34:0]  m3_x, m3_z;
  logic signed [16:0]  m3_py;
  logic signed [15:0]  m3_nx, m3_nz, m3_sb;
  tmvg_pkg::vtx_meta_t m3_meta;

  logic                vo;
  logic signed [47:0]  rc_w, py_w, nx_w, nz_w, x_w, z_w;

  assign rc_w = tmvg_pkg::rnd14(48'(m1_rcb));
  assign py_w = tmvg_pkg::rnd14(48'(m1_rsb));
  assign nx_w = tmvg_pkg::rnd14(48'(m1_nx));
  assign nz_w = tmvg_pkg::rnd14(48'(m1_nz));
  assign x_w  = tmvg_pkg::rnd14(48'(m3_x));
  assign z_w  = tmvg_pkg::rnd14(48'(m3_z));

  assign adv          = !vo || vertex.ready;
  assign vertex.valid = vo;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp  <= 1'b0;
      vm1 <= 1'b0;
      vm2 <= 1'b0;
      vm3 <= 1'b0;
      vo  <= 1'b0;
    end else if (adv) begin
      vp  <= dv[NS-1];
      vm1 <= vp;
      vm2 <= vm1;
      vm3 <= vm2;
      vo  <= vm3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_sb   <= tmvg_pkg::sine_at(pb);
      p_cb   <= tmvg_pkg::sine_at(pb + PW'(tmvg_pkg::QUARTER));
      p_sa   <= tmvg_pkg::sine_at(pa);
      p_ca   <= tmvg_pkg::sine_at(pa + PW'(tmvg_pkg::QUARTER));
      p_meta <= meta_n;

      m1_rcb  <= signed'({1'b0, tube_radius}) * p_cb;
      m1_rsb  <= signed'({1'b0, tube_radius}) * p_sb;
      m1_nx   <= p_cb * p_ca;
      m1_nz   <= p_cb * p_sa;
      m1_sb   <= p_sb;
      m1_sa   <= p_sa;
      m1_ca   <= p_ca;
      m1_meta <= p_meta;

      m2_rad  <= signed'({3'b0, ring_radius}) + 19'(rc_w);
      m2_py   <= 17'(py_w);
      m2_nx   <= 16'(nx_w);
      m2_nz   <= 16'(nz_w);
      m2_sb   <= m1_sb;
      m2_sa   <= m1_sa;
      m2_ca   <= m1_ca;
      m2_meta <= m1_meta;

      m3_x    <= m2_rad * m2_ca;
      m3_z    <= m2_rad * m2_sa;
      m3_py   <= m2_py;
      m3_nx   <= m2_nx;
      m3_nz   <= m2_nz;
      m3_sb   <= m2_sb;
      m3_meta <= m2_meta;

      vertex.pos_x         <= 18'(x_w);
      vertex.pos_y         <= m3_py;
      vertex.pos_z         <= 18'(z_w);
      vertex.norm_x        <= m3_nx;
      vertex.norm_y        <= m3_sb;
      vertex.norm_z        <= m3_nz;
      vertex.tex_u         <= m3_meta.tex_u;
      vertex.tex_v         <= m3_meta.tex_v;
      vertex.vertex_number <= m3_meta.vertex_number;
      vertex.tri_valid     <= m3_meta.tri_valid;
      vertex.tri_base      <= m3_meta.tri_base;
      vertex.last          <= m3_meta.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tmvg_checker.sv =====
// ----------------------------------------------------------------------------
// tmvg_checker
// Port-level checks on the vertex channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmvg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_last,
  input wire logic [17:0] vertex_number,
  input wire logic        tri_valid,
  input wire logic [17:0] tri_base,
  input wire logic [15:0] tex_u,
  input wire logic [15:0] tex_v
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("vertex dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("vertex valid after reset");

  a_tri: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tri_valid |-> tri_base == 18'd0)
    else $error("triangle base without triangle");

  a_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vertex_number[0] == out_last)
    else $error("vertex number parity disagrees with side");

  a_tex: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tex_u <= 16'd32768 && tex_v <= 16'd32768)
    else $error("texture coordinate above one");

endmodule

bind torus_mesh_vertex_generator_top tmvg_checker u_tmvg_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (vertex.valid),
  .out_ready     (vertex.ready),
  .out_last      (vertex.last),
  .vertex_number (vertex.vertex_number),
  .tri_valid     (vertex.tri_valid),
  .tri_base      (vertex.tri_base),
  .tex_u         (vertex.tex_u),
  .tex_v         (vertex.tex_v)
);

`default_nettype wire
